[sv/nfca_anticollision_sequencer_defines.svh]
// assertion macros for the nfca anticollision sequencer
// needs a clock named aclk and an active-low synchronous reset named aresetn in scope
`ifndef NFCA_ANTICOLLISION_SEQUENCER_DEFINES_SVH
`define NFCA_ANTICOLLISION_SEQUENCER_DEFINES_SVH

// property checked at every edge outside reset
`define NFCA_ASSERT(name, prop, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// property checked at every edge, reset included
`define NFCA_ASSERT_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge aclk) (prop)) else $error(msg);

`endif

[sv/nfca_pkg.sv]
// shared types and constants for the nfca anticollision sequencer
// no dependencies
package nfca_pkg;

    // cascade levels handled (one, two or three)
    localparam int MAX_LEVELS = 3;
    localparam int UID_BYTES  = 10;
    localparam int SDD_BYTES  = 5;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_ATQA,
        PH_SDD,
        PH_SAK,
        PH_ACT
    } phase_t;

    // request kinds
    localparam logic REQ_START    = 1'b0;
    localparam logic REQ_RESPONSE = 1'b1;

    // front end result codes
    localparam logic [1:0] RX_OK = 2'd0;

    // action codes
    localparam logic [2:0] ACT_NONE      = 3'd0;
    localparam logic [2:0] ACT_REQA      = 3'd1;
    localparam logic [2:0] ACT_SDD       = 3'd2;
    localparam logic [2:0] ACT_SELECT    = 3'd3;
    localparam logic [2:0] ACT_ACTIVATED = 3'd4;
    localparam logic [2:0] ACT_FAILED    = 3'd5;

    // status codes
    localparam logic [2:0] ST_NONE        = 3'd0;
    localparam logic [2:0] ST_NOT_PRESENT = 3'd1;
    localparam logic [2:0] ST_COMM        = 3'd2;
    localparam logic [2:0] ST_COLL_FAIL   = 3'd3;
    localparam logic [2:0] ST_OVERFLOW    = 3'd4;

    // frame bytes
    localparam logic [7:0] CMD_SEL_CL1 = 8'h93;
    localparam logic [7:0] NVB_SDD     = 8'h20;
    localparam logic [7:0] NVB_SEL     = 8'h70;
    localparam logic [7:0] REQA_CMD    = 8'h26;
    localparam logic [7:0] CASCADE_TAG = 8'h88;

    // frame lengths in bits
    localparam logic [5:0] TXB_REQA   = 6'd7;
    localparam logic [5:0] TXB_SDD    = 6'd16;
    localparam logic [5:0] TXB_SELECT = 6'd56;
    localparam logic [6:0] RXB_ATQA   = 7'd16;
    localparam logic [6:0] RXB_SDD    = 7'(SDD_BYTES * 8);
    localparam logic [6:0] RXB_SAK    = 7'd8;

    typedef struct packed {
        logic        rx_crc_ok;
        logic [39:0] rx_payload;
        logic [6:0]  rx_bit_count;
        logic [1:0]  rx_error;
        logic        req_type;
    } nfca_in_t;

    typedef struct packed {
        logic [7:0]  sak_out;
        logic [15:0] atqa_out;
        logic [3:0]  uid_length;
        logic [15:0] uid_high;
        logic [63:0] uid_low;
        logic [2:0]  status;
        logic [5:0]  tx_bit_count;
        logic [55:0] tx_frame;
        logic [2:0]  action;
    } nfca_out_t;

    // per-transaction part of a result; identity comes from the state registers
    typedef struct packed {
        logic [2:0]  status;
        logic [5:0]  tx_bit_count;
        logic [55:0] tx_frame;
        logic [2:0]  action;
    } nfca_res_t;

endpackage

[sv/nfca_anticollision_sequencer.sv]
// nfca anticollision sequencer top level: state, decision logic and result register
// depends on nfca_pkg and nfca_anticollision_sequencer_defines.svh
`include "nfca_anticollision_sequencer_defines.svh"

// Reader-side ISO 14443-A activation sequencer (REQA, then SDD and SELECT per
// cascade level, up to three levels; bit collisions are not resolved, CRC_A is
// added and checked by the RF front end). Send a start transaction (req_type 0)
// to begin; every response frame from the front end goes in as a transaction
// with req_type 1. Each input transaction produces exactly one result
// transaction: the frame to send next, "activated", "failed" with a status code,
// or "none" for a response that arrives while idle or activated. A start while
// activated just reports the stored identity again. The identity fields of a
// result always show the stored UID, ATQA and SAK after that transaction.
// The result is registered; a new transaction is taken every cycle as long as the
// result register is empty or being drained, so the
// sustained rate is one transaction per clock, limited by the single result
// register that holds a result back while m_ready is low.
module nfca_anticollision_sequencer (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  nfca_pkg::nfca_in_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output nfca_pkg::nfca_out_t m_data
);
    import nfca_pkg::*;

    // sequencer state
    phase_t      phase_reg, phase_next;
    logic [1:0]  level_reg, level_next;
    logic [79:0] uid_reg, uid_next;
    logic [3:0]  uid_count_reg, uid_count_next;
    logic [15:0] atqa_reg, atqa_next;
    logic [7:0]  sak_reg, sak_next;
    logic [39:0] sdd_reply_reg, sdd_reply_next;

    // result register
    logic        m_valid_reg;
    nfca_res_t   res_reg, res_next;

    logic        accept;
    logic        is_start;
    logic        rx_ok;
    logic        atqa_len_ok;
    logic        sdd_ok;
    logic        sak_ok;
    logic        is_cascade;
    logic        last_level;
    logic [7:0]  sel_cmd;
    logic [7:0]  sel_cmd_up;

    // byte i of the stored sdd reply
    function automatic logic [7:0] sdd_byte(input logic [39:0] reply, input logic [2:0] idx);
        logic [7:0] b;
        unique case (idx)
            3'd0:    b = reply[7:0];
            3'd1:    b = reply[15:8];
            3'd2:    b = reply[23:16];
            3'd3:    b = reply[31:24];
            3'd4:    b = reply[39:32];
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    // result slot free now or freed this cycle
    assign s_ready  = !m_valid_reg || m_ready;
    assign accept   = s_valid && s_ready;
    assign is_start = (s_data.req_type == REQ_START);

    // response checks
    assign rx_ok       = (s_data.rx_error == RX_OK);
    assign atqa_len_ok = (s_data.rx_bit_count == RXB_ATQA);
    assign sdd_ok      = rx_ok && (s_data.rx_bit_count == RXB_SDD);
    assign sak_ok      = rx_ok && s_data.rx_crc_ok && (s_data.rx_bit_count == RXB_SAK);
    assign is_cascade  = (sdd_reply_reg[7:0] == CASCADE_TAG);
    assign last_level  = (level_reg >= 2'(MAX_LEVELS - 1));

    // select code of this level and of the next one (0x93, 0x95, 0x97)
    assign sel_cmd    = CMD_SEL_CL1 + {5'd0, level_reg, 1'b0};
    assign sel_cmd_up = CMD_SEL_CL1 + {5'd0, level_reg + 2'd1, 1'b0};

    // next phase
    always_comb begin
        phase_next = phase_reg;
        if (accept) begin
            if (is_start) begin
                phase_next = (phase_reg == PH_ACT) ? PH_ACT : PH_ATQA;
            end else begin
                unique case (phase_reg)
                    PH_ATQA: phase_next = (rx_ok && atqa_len_ok) ? PH_SDD : PH_IDLE;
                    PH_SDD:  phase_next = sdd_ok ? PH_SAK : PH_IDLE;
                    PH_SAK: begin
                        priority if (!sak_ok)                phase_next = PH_IDLE;
                        else if (is_cascade && last_level)   phase_next = PH_IDLE;
                        else if (is_cascade)                 phase_next = PH_SDD;
                        else                                 phase_next = PH_ACT;
                    end
                    default: phase_next = phase_reg;
                endcase
            end
        end
    end

    // datapath and result
    always_comb begin
        logic [3:0] n_bytes;
        logic [2:0] src_ofs;
        logic [3:0] rel;
        res_next       = '0;
        level_next     = level_reg;
        uid_next       = uid_reg;
        uid_count_next = uid_count_reg;
        atqa_next      = atqa_reg;
        sak_next       = sak_reg;
        sdd_reply_next = sdd_reply_reg;
        rel            = '0;
        // cascade levels keep uid bytes 1..3, the last level bytes 0..3
        n_bytes = is_cascade ? 4'd3 : 4'd4;
        src_ofs = is_cascade ? 3'd1 : 3'd0;

        if (is_start) begin
            if (phase_reg == PH_ACT) begin
                res_next.action = ACT_ACTIVATED;
            end else begin
                // restart: identity cleared, REQA out
                level_next            = '0;
                uid_next              = '0;
                uid_count_next        = '0;
                atqa_next             = '0;
                sak_next              = '0;
                sdd_reply_next        = '0;
                res_next.action       = ACT_REQA;
                res_next.tx_frame     = {48'd0, REQA_CMD};
                res_next.tx_bit_count = TXB_REQA;
            end
        end else begin
            unique case (phase_reg)
                PH_ATQA: begin
                    priority if (!rx_ok) begin
                        res_next.action = ACT_FAILED;
                        res_next.status = ST_NOT_PRESENT;
                    end else if (!atqa_len_ok) begin
                        res_next.action = ACT_FAILED;
                        res_next.status = ST_COMM;
                    end else begin
                        atqa_next             = s_data.rx_payload[15:0];
                        level_next            = '0;
                        res_next.action       = ACT_SDD;
                        res_next.tx_frame     = {40'd0, NVB_SDD, CMD_SEL_CL1};
                        res_next.tx_bit_count = TXB_SDD;
                    end
                end
                PH_SDD: begin
                    if (!sdd_ok) begin
                        res_next.action = ACT_FAILED;
                        res_next.status = ST_COLL_FAIL;
                    end else begin
                        sdd_reply_next        = s_data.rx_payload;
                        res_next.action       = ACT_SELECT;
                        res_next.tx_frame     = {s_data.rx_payload, NVB_SEL, sel_cmd};
                        res_next.tx_bit_count = TXB_SELECT;
                    end
                end
                PH_SAK: begin
                    priority if (!sak_ok) begin
                        res_next.action = ACT_FAILED;
                        res_next.status = ST_COLL_FAIL;
                    end else if (is_cascade && last_level) begin
                        res_next.action = ACT_FAILED;
                        res_next.status = ST_OVERFLOW;
                    end else begin
                        // append the new uid bytes at slot uid_count
                        for (int k = 0; k < UID_BYTES; k++) begin
                            rel = 4'(k) - uid_count_reg;
                            if (4'(k) >= uid_count_reg && 4'(k) < uid_count_reg + n_bytes) begin
                                uid_next[8*k +: 8] = sdd_byte(sdd_reply_reg, rel[2:0] + src_ofs);
                            end
                        end
                        uid_count_next = uid_count_reg + n_bytes;
                        if (is_cascade) begin
                            level_next            = level_reg + 2'd1;
                            res_next.action       = ACT_SDD;
                            res_next.tx_frame     = {40'd0, NVB_SDD, sel_cmd_up};
                            res_next.tx_bit_count = TXB_SDD;
                        end else begin
                            sak_next        = s_data.rx_payload[7:0];
                            res_next.action = ACT_ACTIVATED;
                        end
                    end
                end
                default: res_next.action = ACT_NONE;
            endcase
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_IDLE;
            level_reg     <= '0;
            uid_reg       <= '0;
            uid_count_reg <= '0;
            atqa_reg      <= '0;
            sak_reg       <= '0;
            sdd_reply_reg <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            if (accept) begin
                level_reg     <= level_next;
                uid_reg       <= uid_next;
                uid_count_reg <= uid_count_next;
                atqa_reg      <= atqa_next;
                sak_reg       <= sak_next;
                sdd_reply_reg <= sdd_reply_next;
                m_valid_reg   <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // result payload, no reset needed
    always_ff @(posedge aclk) begin
        if (accept) begin
            res_reg <= res_next;
        end
    end

    // identity only changes on accept, which also reloads the result, so the
    // state registers match the pending result
    assign m_valid             = m_valid_reg;
    assign m_data.action       = res_reg.action;
    assign m_data.tx_frame     = res_reg.tx_frame;
    assign m_data.tx_bit_count = res_reg.tx_bit_count;
    assign m_data.status       = res_reg.status;
    assign m_data.uid_low      = uid_reg[63:0];
    assign m_data.uid_high     = uid_reg[79:64];
    assign m_data.uid_length   = uid_count_reg;
    assign m_data.atqa_out     = atqa_reg;
    assign m_data.sak_out      = sak_reg;

    // checks
    `NFCA_ASSERT(a_restart_to_atqa, (accept && is_start && phase_reg != PH_ACT) |=> (phase_reg == PH_ATQA), "start did not restart activation")
    `NFCA_ASSERT(a_uid_tracks_level, (phase_reg == PH_SDD || phase_reg == PH_SAK) |-> (uid_count_reg == 4'(3 * level_reg)), "uid count out of step with cascade level")
    `NFCA_ASSERT(a_activated_phase, (m_valid && res_reg.action == ACT_ACTIVATED) |-> (phase_reg == PH_ACT), "activated result without activated phase")
    `NFCA_ASSERT_ALWAYS(a_no_overwrite, (m_valid && !m_ready) |-> !s_ready, "pending result could be overwritten")

endmodule

[tb/tb_top.sv]
// self-checking testbench for nfca_anticollision_sequencer
// depends on nfca_pkg and the sequencer rtl; predicts every result in-line
`timescale 1ns / 100ps

module tb_top;
    import nfca_pkg::*;

    // front end result codes the package leaves unnamed
    localparam logic [1:0] RX_TIMEOUT = 2'd1;
    localparam logic [1:0] RX_OTHER   = 2'd2;

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    nfca_in_t  s_data;
    logic      m_valid;
    logic      m_ready;
    nfca_out_t m_data;

    // idling knobs, percent of cycles
    int src_idle_pct  = 0;
    int snk_stall_pct = 0;
    // cycles the receiver still has to hold off
    int hold_left = 0;

    int mismatch_count = 0;
    int useful_items   = 0;

    // predicted card activation state
    phase_t      cur_phase;
    logic [1:0]  cur_level;
    logic [79:0] uid_seen;
    logic [3:0]  uid_len;
    logic [15:0] atqa_seen;
    logic [7:0]  sak_seen;
    logic [39:0] sdd_seen;

    // results still owed by the block, oldest first
    nfca_out_t pending_outcomes[$];

    nfca_anticollision_sequencer u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // run limit, far beyond the slowest legal run
    initial begin
        #2000000;
        $display("TB_ERROR");
        $finish;
    end

    // ---------------------------------------------------------------
    // prediction
    // ---------------------------------------------------------------

    function automatic void forget_identity();
        cur_phase = PH_IDLE;
        cur_level = '0;
        uid_seen  = '0;
        uid_len   = '0;
        atqa_seen = '0;
        sak_seen  = '0;
        sdd_seen  = '0;
    endfunction

    // sdd request for the current cascade level
    function automatic logic [55:0] sdd_request();
        logic [7:0] cmd;
        cmd = CMD_SEL_CL1 + {cur_level, 1'b0};
        return 56'({NVB_SDD, cmd});
    endfunction

    // advance the activation state by one transaction and give the result
    function automatic nfca_out_t step_activation(nfca_in_t it);
        nfca_out_t  r;
        logic [7:0] cmd;
        int         idx;
        r = '0;
        if (it.req_type == REQ_START) begin
            if (cur_phase == PH_ACT) begin
                // already active: just report the identity again
                r.action = ACT_ACTIVATED;
            end else begin
                forget_identity();
                cur_phase      = PH_ATQA;
                r.action       = ACT_REQA;
                r.tx_frame     = 56'(REQA_CMD);
                r.tx_bit_count = TXB_REQA;
            end
        end else begin
            case (cur_phase)
                PH_ATQA: begin
                    if (it.rx_error != RX_OK) begin
                        cur_phase = PH_IDLE;
                        r.action  = ACT_FAILED;
                        r.status  = ST_NOT_PRESENT;
                    end else if (it.rx_bit_count != RXB_ATQA) begin
                        cur_phase = PH_IDLE;
                        r.action  = ACT_FAILED;
                        r.status  = ST_COMM;
                    end else begin
                        atqa_seen      = it.rx_payload[15:0];
                        cur_level      = '0;
                        cur_phase      = PH_SDD;
                        r.action       = ACT_SDD;
                        r.tx_frame     = sdd_request();
                        r.tx_bit_count = TXB_SDD;
                    end
                end
                PH_SDD: begin
                    if (it.rx_error != RX_OK || it.rx_bit_count != RXB_SDD) begin
                        cur_phase = PH_IDLE;
                        r.action  = ACT_FAILED;
                        r.status  = ST_COLL_FAIL;
                    end else begin
                        sdd_seen       = it.rx_payload;
                        cmd            = CMD_SEL_CL1 + {cur_level, 1'b0};
                        cur_phase      = PH_SAK;
                        r.action       = ACT_SELECT;
                        r.tx_frame     = {sdd_seen, NVB_SEL, cmd};
                        r.tx_bit_count = TXB_SELECT;
                    end
                end
                PH_SAK: begin
                    if (it.rx_error != RX_OK || !it.rx_crc_ok || it.rx_bit_count != RXB_SAK) begin
                        cur_phase = PH_IDLE;
                        r.action  = ACT_FAILED;
                        r.status  = ST_COLL_FAIL;
                    end else if (sdd_seen[7:0] == CASCADE_TAG) begin
                        if (int'(cur_level) + 1 >= MAX_LEVELS) begin
                            cur_phase = PH_IDLE;
                            r.action  = ACT_FAILED;
                            r.status  = ST_OVERFLOW;
                        end else begin
                            // cascade tag: keep bytes 1..3 and go one level down
                            for (int i = 1; i < 4; i++) begin
                                idx = int'(uid_len) + i - 1;
                                if (idx < UID_BYTES)
                                    uid_seen[8*idx +: 8] = sdd_seen[8*i +: 8];
                            end
                            uid_len        = uid_len + 4'd3;
                            cur_level      = cur_level + 2'd1;
                            cur_phase      = PH_SDD;
                            r.action       = ACT_SDD;
                            r.tx_frame     = sdd_request();
                            r.tx_bit_count = TXB_SDD;
                        end
                    end else begin
                        for (int i = 0; i < 4; i++) begin
                            idx = int'(uid_len) + i;
                            if (idx < UID_BYTES)
                                uid_seen[8*idx +: 8] = sdd_seen[8*i +: 8];
                        end
                        uid_len   = uid_len + 4'd4;
                        sak_seen  = it.rx_payload[7:0];
                        cur_phase = PH_ACT;
                        r.action  = ACT_ACTIVATED;
                    end
                end
                default: begin
                    // response while idle or active is dropped
                    r.action = ACT_NONE;
                end
            endcase
        end
        r.uid_low    = uid_seen[63:0];
        r.uid_high   = uid_seen[79:64];
        r.uid_length = uid_len;
        r.atqa_out   = atqa_seen;
        r.sak_out    = sak_seen;
        return r;
    endfunction

    // ---------------------------------------------------------------
    // transaction builders
    // ---------------------------------------------------------------

    function automatic logic [39:0] random_bytes();
        logic [63:0] r64;
        r64 = {$urandom(), $urandom()};
        return r64[39:0];
    endfunction

    function automatic nfca_in_t rx_frame(logic [1:0] err, logic [6:0] bits,
                                          logic [39:0] data, logic crc);
        nfca_in_t it;
        it.req_type     = REQ_RESPONSE;
        it.rx_error     = err;
        it.rx_bit_count = bits;
        it.rx_payload   = data;
        it.rx_crc_ok    = crc;
        return it;
    endfunction

    // fully random transaction, out-of-order noise
    function automatic nfca_in_t any_item();
        nfca_in_t it;
        it.req_type     = 1'($urandom_range(0, 1));
        it.rx_error     = 2'($urandom_range(0, 2));
        it.rx_bit_count = 7'($urandom_range(0, 64));
        it.rx_payload   = random_bytes();
        it.rx_crc_ok    = 1'($urandom_range(0, 1));
        return it;
    endfunction

    // start request; the other fields are don't-care, so they are scrambled
    function automatic nfca_in_t start_item();
        nfca_in_t it;
        it          = any_item();
        it.req_type = REQ_START;
        return it;
    endfunction

    // response that fits the phase, mostly well formed
    function automatic nfca_in_t response_frame(phase_t ph);
        nfca_in_t   it;
        logic [6:0] want;
        logic [6:0] other;
        case (ph)
            PH_ATQA: want = RXB_ATQA;
            PH_SDD:  want = RXB_SDD;
            default: want = RXB_SAK;
        endcase
        it = rx_frame(RX_OK, want, random_bytes(), 1'b1);
        if (ph == PH_SDD && $urandom_range(0, 99) < 45)
            it.rx_payload[7:0] = CASCADE_TAG;
        if (ph != PH_SAK)
            it.rx_crc_ok = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 99) < 8) begin
            case ($urandom_range(0, 2))
                0: it.rx_error = 2'($urandom_range(1, 2));
                1: begin
                    do other = 7'($urandom_range(0, 64)); while (other == want);
                    it.rx_bit_count = other;
                end
                default: it.rx_crc_ok = 1'b0;
            endcase
        end
        return it;
    endfunction

    // ---------------------------------------------------------------
    // driving and checking
    // ---------------------------------------------------------------

    // offer one transaction; called and returns at a falling edge
    task automatic send_item(nfca_in_t it);
        int        gap;
        nfca_out_t want;
        gap = 0;
        while ($urandom_range(0, 99) < src_idle_pct)
            gap++;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (s_ready !== 1'b1);
        // accepted at this edge
        want = step_activation(it);
        pending_outcomes.push_back(want);
        if (want.action != ACT_NONE)
            useful_items++;
        @(negedge aclk);
    endtask

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        mismatch_count++;
        $display("%0t mismatch on %s: got %h, want %h", $realtime, what, got, want);
    endtask

    // receiver: random stalls plus an optional long hold-off
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= snk_stall_pct);
            end
        end
    end

    // compare every result transaction with the oldest prediction
    always @(posedge aclk) begin
        nfca_out_t want;
        if (aresetn && m_valid === 1'b1 && m_ready === 1'b1) begin
            if (pending_outcomes.size() == 0) begin
                report_mismatch("unexpected result, action", 64'(m_data.action), '0);
            end else begin
                want = pending_outcomes.pop_front();
                if (m_data.action !== want.action)
                    report_mismatch("action", 64'(m_data.action), 64'(want.action));
                if (m_data.tx_frame !== want.tx_frame)
                    report_mismatch("tx_frame", 64'(m_data.tx_frame), 64'(want.tx_frame));
                if (m_data.tx_bit_count !== want.tx_bit_count)
                    report_mismatch("tx_bit_count", 64'(m_data.tx_bit_count),
                                    64'(want.tx_bit_count));
                if (m_data.status !== want.status)
                    report_mismatch("status", 64'(m_data.status), 64'(want.status));
                if (m_data.uid_low !== want.uid_low)
                    report_mismatch("uid_low", m_data.uid_low, want.uid_low);
                if (m_data.uid_high !== want.uid_high)
                    report_mismatch("uid_high", 64'(m_data.uid_high), 64'(want.uid_high));
                if (m_data.uid_length !== want.uid_length)
                    report_mismatch("uid_length", 64'(m_data.uid_length),
                                    64'(want.uid_length));
                if (m_data.atqa_out !== want.atqa_out)
                    report_mismatch("atqa_out", 64'(m_data.atqa_out), 64'(want.atqa_out));
                if (m_data.sak_out !== want.sak_out)
                    report_mismatch("sak_out", 64'(m_data.sak_out), 64'(want.sak_out));
            end
        end
    end

    // ---------------------------------------------------------------
    // stimulus
    // ---------------------------------------------------------------

    // one activation attempt: start, then responses until it ends
    task automatic run_one_session();
        send_item(start_item());
        while (cur_phase == PH_ATQA || cur_phase == PH_SDD || cur_phase == PH_SAK) begin
            // rare restart in the middle of an activation
            if ($urandom_range(0, 99) < 3)
                send_item(start_item());
            else
                send_item(response_frame(cur_phase));
        end
        if (cur_phase == PH_ACT && $urandom_range(0, 99) < 40) begin
            if ($urandom_range(0, 1) == 0)
                send_item(start_item());
            else
                send_item(any_item());
        end
    endtask

    // well-formed sessions with random content, plus some noise
    task automatic run_sessions(int target);
        int first;
        first = useful_items;
        while (useful_items - first < target) begin
            if ($urandom_range(0, 99) < 12)
                send_item(any_item());
            else
                run_one_session();
        end
    endtask

    // error paths: ignored response, bad atqa, bad sdd length
    task automatic test_activation_errors();
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        send_item(rx_frame(RX_OK, RXB_ATQA, 40'h0, 1'b1));
        send_item(start_item());
        send_item(rx_frame(RX_OTHER, RXB_ATQA, 40'h0, 1'b1));
        send_item(start_item());
        send_item(rx_frame(RX_OK, 7'd0, 40'h0, 1'b0));
        send_item(start_item());
        send_item(rx_frame(RX_OK, RXB_ATQA, 40'hFF_FFFF_FFFF, 1'b1));
        send_item(rx_frame(RX_OK, 7'd64, 40'hFF_FFFF_FFFF, 1'b1));
        send_item(start_item());
        send_item(rx_frame(RX_TIMEOUT, 7'd0, 40'h0, 1'b0));
    endtask

    // broken sak crc, cascade overflow at the last level, then a plain single-size card
    task automatic test_cascade_levels();
        send_item(start_item());
        send_item(rx_frame(RX_OK, RXB_ATQA, 40'h00_0000_0044, 1'b1));
        send_item(rx_frame(RX_OK, RXB_SDD, 40'h0000000000, 1'b0));
        // sak with a broken crc
        send_item(rx_frame(RX_OK, RXB_SAK, 40'h04, 1'b0));
        send_item(start_item());
        send_item(rx_frame(RX_OK, RXB_ATQA, 40'h00_0000_0044, 1'b1));
        for (int lvl = 0; lvl < MAX_LEVELS; lvl++) begin
            send_item(rx_frame(RX_OK, RXB_SDD, {8'hA0, 8'h30 + 8'(lvl), 16'h2211, CASCADE_TAG},
                               1'b1));
            send_item(rx_frame(RX_OK, RXB_SAK, 40'h04, 1'b1));
        end
        // single level card with all-ones content, then a random transaction and a start while active
        send_item(start_item());
        send_item(rx_frame(RX_OK, RXB_ATQA, 40'hFF_FFFF_FFFF, 1'b1));
        send_item(rx_frame(RX_OK, RXB_SDD, 40'hFF_FFFF_FFFF, 1'b1));
        send_item(rx_frame(RX_OK, RXB_SAK, 40'hFF_FFFF_FFFF, 1'b1));
        send_item(any_item());
        send_item(start_item());
    endtask

    // receiver holds off for a long time while the sender keeps offering
    task automatic test_backpressure_fill();
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        hold_left     = 150;
        run_sessions(30);
    endtask

    task automatic test_random_traffic(int src_pct, int snk_pct, int n);
        src_idle_pct  = src_pct;
        snk_stall_pct = snk_pct;
        run_sessions(n);
    endtask

    // ---------------------------------------------------------------
    // main sequence
    // ---------------------------------------------------------------
    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data  = '0;
        forget_identity();
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_activation_errors();
        test_cascade_levels();
        test_backpressure_fill();
        test_random_traffic(0, 0, 440);
        test_random_traffic(59, 0, 440);
        test_random_traffic(0, 59, 440);
        test_random_traffic(13, 13, 430);

        s_valid <= 1'b0;
        // let every owed result drain, then watch for stray ones
        while (pending_outcomes.size() != 0)
            @(posedge aclk);
        repeat (20) @(posedge aclk);

        if (mismatch_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

[sim.f]
+incdir+sv
sv/nfca_pkg.sv
sv/nfca_anticollision_sequencer.sv
tb/tb_top.sv
